FILE: hdl/sti_pkg.sv
// ---------------------------------------------------------------------------
// sti_pkg
// Shared widths, types and helpers for the segment/triangle intersection
// pipeline.
// ---------------------------------------------------------------------------
package sti_pkg;

  localparam int COORD_W = 21;
  localparam int POINT_W = 63;
  localparam int EPS_W   = 20;
  localparam logic [EPS_W-1:0] EPS_RESET = 20'd107;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int LO_W    = (CROSS_W + 1) / 2;
  localparam int HI_W    = CROSS_W - LO_W;
  localparam int PLO_W   = DIFF_W + LO_W + 1;
  localparam int PHI_W   = DIFF_W + HI_W;
  localparam int DOTP_W  = DIFF_W + CROSS_W;
  localparam int DOT_W   = DOTP_W + 2;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } diff_vec_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } cross_vec_t;

  typedef struct packed {
    diff_vec_t dir;
    diff_vec_t e1;
    diff_vec_t e2;
    diff_vec_t tv;
  } edge_set_t;

  typedef struct packed {
    cross_vec_t pv;
    cross_vec_t qv;
  } cross_set_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] det;
    logic signed [DOT_W-1:0] u;
    logic signed [DOT_W-1:0] v;
    logic signed [DOT_W-1:0] sp;
  } dot_set_t;

  // Difference a - b of two packed points, coordinate by coordinate.
  function automatic diff_vec_t vec_diff(input logic [POINT_W-1:0] a,
                                         input logic [POINT_W-1:0] b);
    diff_vec_t r;
    r.x = DIFF_W'(signed'(a[0 +: COORD_W])) - DIFF_W'(signed'(b[0 +: COORD_W]));
    r.y = DIFF_W'(signed'(a[COORD_W +: COORD_W]))
        - DIFF_W'(signed'(b[COORD_W +: COORD_W]));
    r.z = DIFF_W'(signed'(a[2*COORD_W +: COORD_W]))
        - DIFF_W'(signed'(b[2*COORD_W +: COORD_W]));
    return r;
  endfunction

endpackage

FILE: hdl/sti_seg_if.sv
// ---------------------------------------------------------------------------
// sti_seg_if
// Request channel: one segment and one triangle per item.
// ---------------------------------------------------------------------------
interface sti_seg_if import sti_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POINT_W-1:0] seg_start;
  logic [POINT_W-1:0] seg_end;
  logic [POINT_W-1:0] tri_v0;
  logic [POINT_W-1:0] tri_v1;
  logic [POINT_W-1:0] tri_v2;

  modport source(output valid, seg_start, seg_end, tri_v0, tri_v1, tri_v2,
                 input ready);
  modport sink(input valid, seg_start, seg_end, tri_v0, tri_v1, tri_v2,
               output ready);
endinterface

FILE: hdl/sti_hit_if.sv
// ---------------------------------------------------------------------------
// sti_hit_if
// Result channel: one hit flag per item.
// ---------------------------------------------------------------------------
interface sti_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source(output valid, hit, input ready);
  modport sink(input valid, hit, output ready);
endinterface

FILE: hdl/sti_cfg_if.sv
// ---------------------------------------------------------------------------
// sti_cfg_if
// Configuration write channel for the determinant threshold.
// ---------------------------------------------------------------------------
interface sti_cfg_if import sti_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EPS_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

FILE: hdl/sti_cross.sv
// ---------------------------------------------------------------------------
// sti_cross
// Stages 1 to 3: edge vectors, cross product terms, cross products.
// ---------------------------------------------------------------------------
module sti_cross import sti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [POINT_W-1:0] seg_start,
  input  logic [POINT_W-1:0] seg_end,
  input  logic [POINT_W-1:0] tri_v0,
  input  logic [POINT_W-1:0] tri_v1,
  input  logic [POINT_W-1:0] tri_v2,
  output logic               out_valid,
  output edge_set_t          edges,
  output cross_set_t         cross_set
);

  logic                     v1, v2, v3;
  edge_set_t                ed1, ed2, ed3;
  logic signed [PROD_W-1:0] prod [12];
  cross_set_t               cr3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ed1.dir <= vec_diff(seg_end, seg_start);
      ed1.e1  <= vec_diff(tri_v1, tri_v0);
      ed1.e2  <= vec_diff(tri_v2, tri_v0);
      ed1.tv  <= vec_diff(seg_start, tri_v0);

      ed2      <= ed1;
      prod[0]  <= PROD_W'(ed1.dir.y) * PROD_W'(ed1.e2.z);
      prod[1]  <= PROD_W'(ed1.dir.z) * PROD_W'(ed1.e2.y);
      prod[2]  <= PROD_W'(ed1.dir.z) * PROD_W'(ed1.e2.x);
      prod[3]  <= PROD_W'(ed1.dir.x) * PROD_W'(ed1.e2.z);
      prod[4]  <= PROD_W'(ed1.dir.x) * PROD_W'(ed1.e2.y);
      prod[5]  <= PROD_W'(ed1.dir.y) * PROD_W'(ed1.e2.x);
      prod[6]  <= PROD_W'(ed1.tv.y) * PROD_W'(ed1.e1.z);
      prod[7]  <= PROD_W'(ed1.tv.z) * PROD_W'(ed1.e1.y);
      prod[8]  <= PROD_W'(ed1.tv.z) * PROD_W'(ed1.e1.x);
      prod[9]  <= PROD_W'(ed1.tv.x) * PROD_W'(ed1.e1.z);
      prod[10] <= PROD_W'(ed1.tv.x) * PROD_W'(ed1.e1.y);
      prod[11] <= PROD_W'(ed1.tv.y) * PROD_W'(ed1.e1.x);

      ed3      <= ed2;
      cr3.pv.x <= CROSS_W'(prod[0]) - CROSS_W'(prod[1]);
      cr3.pv.y <= CROSS_W'(prod[2]) - CROSS_W'(prod[3]);
      cr3.pv.z <= CROSS_W'(prod[4]) - CROSS_W'(prod[5]);
      cr3.qv.x <= CROSS_W'(prod[6]) - CROSS_W'(prod[7]);
      cr3.qv.y <= CROSS_W'(prod[8]) - CROSS_W'(prod[9]);
      cr3.qv.z <= CROSS_W'(prod[10]) - CROSS_W'(prod[11]);
    end
  end

  assign out_valid = v3;
  assign edges     = ed3;
  assign cross_set = cr3;

endmodule

FILE: hdl/sti_dot.sv
// ---------------------------------------------------------------------------
// sti_dot
// Stages 4 to 6: the four dot products det, u, v and s, each product split
// into a low and a high partial product of the cross term.
// ---------------------------------------------------------------------------
module sti_dot import sti_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  edge_set_t  edges,
  input  cross_set_t cross_set,
  output logic       out_valid,
  output dot_set_t   dots
);

  logic                      v4, v5, v6;
  logic signed [DIFF_W-1:0]  opa [12];
  logic signed [CROSS_W-1:0] opb [12];
  logic signed [PLO_W-1:0]   plo [12];
  logic signed [PHI_W-1:0]   phi [12];
  logic signed [DOTP_W-1:0]  prod [12];
  dot_set_t                  d6;

  always_comb begin
    opa[0]  = edges.e1.x;  opb[0]  = cross_set.pv.x;
    opa[1]  = edges.e1.y;  opb[1]  = cross_set.pv.y;
    opa[2]  = edges.e1.z;  opb[2]  = cross_set.pv.z;
    opa[3]  = edges.tv.x;  opb[3]  = cross_set.pv.x;
    opa[4]  = edges.tv.y;  opb[4]  = cross_set.pv.y;
    opa[5]  = edges.tv.z;  opb[5]  = cross_set.pv.z;
    opa[6]  = edges.dir.x; opb[6]  = cross_set.qv.x;
    opa[7]  = edges.dir.y; opb[7]  = cross_set.qv.y;
    opa[8]  = edges.dir.z; opb[8]  = cross_set.qv.z;
    opa[9]  = edges.e2.x;  opb[9]  = cross_set.qv.x;
    opa[10] = edges.e2.y;  opb[10] = cross_set.qv.y;
    opa[11] = edges.e2.z;  opb[11] = cross_set.qv.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        plo[k]  <= PLO_W'(opa[k]) * PLO_W'(signed'({1'b0, opb[k][LO_W-1:0]}));
        phi[k]  <= PHI_W'(opa[k]) * PHI_W'(signed'(opb[k][CROSS_W-1:LO_W]));
        prod[k] <= (DOTP_W'(phi[k]) <<< LO_W) + DOTP_W'(plo[k]);
      end
      d6.det <= DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]);
      d6.u   <= DOT_W'(prod[3]) + DOT_W'(prod[4]) + DOT_W'(prod[5]);
      d6.v   <= DOT_W'(prod[6]) + DOT_W'(prod[7]) + DOT_W'(prod[8]);
      d6.sp  <= DOT_W'(prod[9]) + DOT_W'(prod[10]) + DOT_W'(prod[11]);
    end
  end

  assign out_valid = v6;
  assign dots      = d6;

endmodule

FILE: hdl/sti_decide.sv
// ---------------------------------------------------------------------------
// sti_decide
// Stages 7 and 8: sign normalization by the determinant, then the bound
// tests that give the hit flag.
// ---------------------------------------------------------------------------
module sti_decide import sti_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  dot_set_t         dots,
  input  logic [EPS_W-1:0] det_epsilon,
  output logic             out_valid,
  output logic             hit
);

  logic                    v7, v8;
  logic                    flip;
  dot_set_t                n7;
  logic signed [DOT_W-1:0] uv_sum;
  logic                    parallel;
  logic                    u_ok, v_ok, s_ok;
  logic                    hit8;

  assign flip = dots.det[DOT_W-1];

  assign uv_sum   = n7.u + n7.v;
  assign parallel = (n7.det == '0) || (n7.det < signed'(DOT_W'(det_epsilon)));
  assign u_ok     = !n7.u[DOT_W-1] && (n7.u <= n7.det);
  assign v_ok     = !n7.v[DOT_W-1] && (uv_sum <= n7.det);
  assign s_ok     = !n7.sp[DOT_W-1] && (n7.sp <= n7.det);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v7 <= in_valid;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n7.det <= flip ? -dots.det : dots.det;
      n7.u   <= flip ? -dots.u : dots.u;
      n7.v   <= flip ? -dots.v : dots.v;
      n7.sp  <= flip ? -dots.sp : dots.sp;
      hit8   <= !parallel && u_ok && v_ok && s_ok;
    end
  end

  assign out_valid = v8;
  assign hit       = hit8;

endmodule

FILE: hdl/segment_triangle_intersect.sv
// ---------------------------------------------------------------------------
// segment_triangle_intersect
// Segment against triangle intersection test in exact fixed point.
//
//   channel  direction  payload
//   req      in         seg_start, seg_end, tri_v0, tri_v1, tri_v2
//   rsp      out        hit
//   cfg      in         data (det_epsilon)
//
// One item is accepted per cycle while the pipeline is not stalled.
// The eight register stages form one pipeline that advances whenever the
// last stage is empty or its result is taken, so a stall holds every item.
// Reset clears all valid bits and sets det_epsilon to its default value.
// ---------------------------------------------------------------------------
module segment_triangle_intersect import sti_pkg::*; (
  input logic      clk,
  input logic      rst,
  sti_seg_if.sink  req,
  sti_hit_if.source rsp,
  sti_cfg_if.sink  cfg
);

  logic             adv;
  logic [EPS_W-1:0] det_epsilon;
  logic             cross_valid, dot_valid;
  edge_set_t        edges;
  cross_set_t       cross_set;
  dot_set_t         dots;

  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= EPS_RESET;
    end else if (cfg.valid) begin
      det_epsilon <= cfg.data;
    end
  end

  sti_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (req.valid),
    .seg_start (req.seg_start),
    .seg_end   (req.seg_end),
    .tri_v0    (req.tri_v0),
    .tri_v1    (req.tri_v1),
    .tri_v2    (req.tri_v2),
    .out_valid (cross_valid),
    .edges     (edges),
    .cross_set (cross_set)
  );

  sti_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (cross_valid),
    .edges     (edges),
    .cross_set (cross_set),
    .out_valid (dot_valid),
    .dots      (dots)
  );

  sti_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (dot_valid),
    .dots        (dots),
    .det_epsilon (det_epsilon),
    .out_valid   (rsp.valid),
    .hit         (rsp.hit)
  );

endmodule
